// ===== rtl/lct_pkg.sv =====
package lct_pkg;

  localparam int TABLE_DEPTH_DEF = 16;
  localparam int MAX_EMIT        = 16;
  localparam int CFG_W           = 5;
  localparam int ADDR_W          = 32;
  localparam int PORT_W          = 16;
  localparam int IN_TDATA_W      = 48;
  localparam int OUT_TDATA_W     = 56;
  localparam logic [CFG_W-1:0] LIMIT_RESET = 5'd16;

  localparam logic KIND_MSG  = 1'b0;
  localparam logic KIND_DISC = 1'b1;

  typedef enum logic [1:0] {
    STAT_BCAST   = 2'd0,
    STAT_REMOVED = 2'd1,
    STAT_UNKNOWN = 2'd2
  } status_t;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [PORT_W-1:0] port;
  } ent_t;

  typedef struct packed {
    ent_t    ent;
    status_t status;
    logic    evicted;
    logic    last;
  } item_t;

endpackage

// ===== rtl/lru_client_table_broadcast_core.sv =====
// Recency-ordered client table, oldest entry first. A message word (tuser 0)
// moves a known client to the newest slot or appends a new one, evicting the
// oldest entries past the client limit, then streams every active entry from
// oldest to newest with tlast on the newest. A disconnect word (tuser 1)
// removes a matching entry and returns one status word. Each input word runs
// two passes over the table memory (one write port, one read port), one
// entry per cycle unless the output side stalls the compaction: a search with
// one shared comparator, then a compaction pass that rewrites the table in
// place and emits the recipients. in_tready is low from accept until the
// word is done, including any time the output side stalls.
module lru_client_table_broadcast_core #(
  parameter int TABLE_DEPTH = lct_pkg::TABLE_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // cfg: client_limit
  input  logic                            cfg_we,
  input  logic [lct_pkg::CFG_W-1:0]       cfg_wdata,
  // in_tdata: client_addr[31:0], client_port[47:32]
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [lct_pkg::IN_TDATA_W-1:0]  in_tdata,
  // in_tuser: kind
  input  logic                            in_tuser,
  // out_tdata: dest_addr[31:0], dest_port[47:32], evicted[48], zero pad
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [lct_pkg::OUT_TDATA_W-1:0] out_tdata,
  // out_tuser: status
  output logic [1:0]                      out_tuser,
  output logic                            out_tlast
);

  localparam int CAP = (TABLE_DEPTH < lct_pkg::MAX_EMIT) ? TABLE_DEPTH : lct_pkg::MAX_EMIT;
  localparam int AW  = $clog2(TABLE_DEPTH);
  localparam int CW  = $clog2(TABLE_DEPTH + 1);
  localparam logic [lct_pkg::CFG_W-1:0] CAP_L = lct_pkg::CFG_W'(CAP);

  typedef enum logic [3:0] {
    ST_IDLE    = 4'b0001,
    ST_SEARCH  = 4'b0010,
    ST_COMPACT = 4'b0100,
    ST_FIN     = 4'b1000
  } state_t;

  state_t                    state_r, state_nxt;
  logic                      kind_r;
  lct_pkg::ent_t             key_r;
  logic [lct_pkg::CFG_W-1:0] limit_r;
  logic [CW-1:0]             count_r, count_nxt;
  logic [CW-1:0]             idx_r, idx_nxt;
  logic [CW-1:0]             wr_r, wr_nxt;
  logic [CW-1:0]             pos_r, pos_nxt;
  logic [CW-1:0]             drop_r, drop_nxt;
  logic                      found_r, found_nxt;
  logic                      ev_r, ev_nxt;

  lct_pkg::ent_t             mem [TABLE_DEPTH];
  lct_pkg::ent_t             rd_data_r;
  logic                      mem_we;
  lct_pkg::ent_t             mem_wdata;

  logic                      out_load, out_free;
  lct_pkg::item_t            out_item_nxt, out_item;

  logic [lct_pkg::CFG_W-1:0] lim_l;
  logic [CW-1:0]             lim;
  logic                      hit;
  logic [CW-1:0]             drop_calc;

  assign in_tready = rst_n && (state_r == ST_IDLE);

  // saturate the limit to 1 .. CAP
  assign lim_l = (limit_r == '0) ? lct_pkg::CFG_W'(1) : ((limit_r > CAP_L) ? CAP_L : limit_r);
  assign lim   = CW'(lim_l);
  assign hit   = (rd_data_r == key_r);

  always_comb begin
    if (kind_r == lct_pkg::KIND_DISC) begin
      drop_calc = '0;
    end else if (found_r) begin
      drop_calc = (count_r > lim) ? (count_r - lim) : '0;
    end else begin
      drop_calc = (count_r >= lim) ? (count_r - lim + CW'(1)) : '0;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    idx_nxt      = idx_r;
    wr_nxt       = wr_r;
    pos_nxt      = pos_r;
    drop_nxt     = drop_r;
    found_nxt    = found_r;
    ev_nxt       = ev_r;
    mem_we       = 1'b0;
    mem_wdata    = rd_data_r;
    out_load     = 1'b0;
    out_item_nxt = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = ST_SEARCH;
          idx_nxt   = '0;
          found_nxt = 1'b0;
        end
      end
      ST_SEARCH: begin
        if (idx_r == count_r) begin
          state_nxt = ST_COMPACT;
          idx_nxt   = '0;
          wr_nxt    = '0;
          drop_nxt  = drop_calc;
          ev_nxt    = (drop_calc != '0);
        end else begin
          if (hit && !found_r) begin
            found_nxt = 1'b1;
            pos_nxt   = idx_r;
          end
          idx_nxt = idx_r + CW'(1);
        end
      end
      ST_COMPACT: begin
        if (idx_r == count_r) begin
          state_nxt = ST_FIN;
        end else if (found_r && idx_r == pos_r) begin
          idx_nxt = idx_r + CW'(1);
        end else if (drop_r != '0) begin
          // evict the oldest remaining entry
          drop_nxt = drop_r - CW'(1);
          idx_nxt  = idx_r + CW'(1);
        end else if (kind_r == lct_pkg::KIND_DISC || out_free) begin
          mem_we  = 1'b1;
          wr_nxt  = wr_r + CW'(1);
          idx_nxt = idx_r + CW'(1);
          if (kind_r == lct_pkg::KIND_MSG) begin
            out_load             = 1'b1;
            out_item_nxt.ent     = rd_data_r;
            out_item_nxt.status  = lct_pkg::STAT_BCAST;
            out_item_nxt.evicted = ev_r;
            out_item_nxt.last    = 1'b0;
          end
        end
      end
      ST_FIN: begin
        if (out_free) begin
          out_load          = 1'b1;
          out_item_nxt.last = 1'b1;
          state_nxt         = ST_IDLE;
          if (kind_r == lct_pkg::KIND_MSG) begin
            mem_we               = 1'b1;
            mem_wdata            = key_r;
            out_item_nxt.ent     = key_r;
            out_item_nxt.status  = lct_pkg::STAT_BCAST;
            out_item_nxt.evicted = ev_r;
            count_nxt            = wr_r + CW'(1);
          end else begin
            out_item_nxt.status = found_r ? lct_pkg::STAT_REMOVED : lct_pkg::STAT_UNKNOWN;
            count_nxt           = wr_r;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
      limit_r <= lct_pkg::LIMIT_RESET;
      idx_r   <= '0;
      wr_r    <= '0;
      pos_r   <= '0;
      drop_r  <= '0;
      found_r <= 1'b0;
      ev_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      idx_r   <= idx_nxt;
      wr_r    <= wr_nxt;
      pos_r   <= pos_nxt;
      drop_r  <= drop_nxt;
      found_r <= found_nxt;
      ev_r    <= ev_nxt;
      if (cfg_we) begin
        limit_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      kind_r     <= in_tuser;
      key_r.addr <= in_tdata[31:0];
      key_r.port <= in_tdata[47:32];
    end
  end

  // table memory: one write port, registered read that follows the scan index
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_r[AW-1:0]] <= mem_wdata;
    end
    rd_data_r <= mem[idx_nxt[AW-1:0]];
  end

  lct_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (out_load),
    .item       (out_item_nxt),
    .free       (out_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_item   (out_item)
  );

  assign out_tdata = {7'b0, out_item.evicted, out_item.ent.port, out_item.ent.addr};
  assign out_tuser = out_item.status;
  assign out_tlast = out_item.last;

endmodule

// ===== rtl/lct_out_stage.sv =====
module lct_out_stage (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           load,
  input  lct_pkg::item_t item,
  output logic           free,
  output logic           out_tvalid,
  input  logic           out_tready,
  output lct_pkg::item_t out_item
);

  logic           valid_r;
  lct_pkg::item_t item_r;

  // slot can take a new word when empty or when the held word leaves now
  assign free       = !valid_r || out_tready;
  assign out_tvalid = valid_r;
  assign out_item   = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_tready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= item;
    end
  end

endmodule

// ===== rtl/lct_checker.sv =====
module lct_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [lct_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic [1:0]                      out_tuser,
  input logic                            out_tlast
);

  // a stalled word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser)
      && $stable(out_tlast))
    else $error("output word changed while stalled");

  // status words close the burst and carry no endpoint
  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != lct_pkg::STAT_BCAST |-> out_tlast && out_tdata == '0)
    else $error("status word not last or not zero");

  // no new input while a burst is still being delivered
  a_busy_in_burst: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> !in_tready)
    else $error("input ready in the middle of a burst");

  // an accepted input keeps the block busy for the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input ready right after accept");

  // only defined status codes leave the block
  a_status_known: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser <= lct_pkg::STAT_UNKNOWN)
    else $error("undefined status code on output");

endmodule

bind lru_client_table_broadcast_core lct_checker u_lct_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

// ===== tb/tb_lru_client_table_broadcast_core.sv =====
`timescale 1ns / 1ps

module tb_lru_client_table_broadcast_core;
  import lct_pkg::*;

  localparam int DEPTH      = TABLE_DEPTH_DEF;
  localparam int POOL_SIZE  = 24;
  localparam int MAX_CYCLES = 600000;

  // Mirrors the client table and holds the recipient words still due.
  class lct_scoreboard;
    logic [ADDR_W-1:0] slot_addr[DEPTH];
    logic [PORT_W-1:0] slot_port[DEPTH];
    int                active;
    logic [CFG_W-1:0]  client_limit;
    item_t             due_words[$];
    int                mismatches;

    function new();
      active       = 0;
      client_limit = LIMIT_RESET;
      mismatches   = 0;
    endfunction

    function void set_limit(logic [CFG_W-1:0] v);
      client_limit = v;
    endfunction

    function int pending();
      return due_words.size();
    endfunction

    function int limit_in_force();
      int cap;
      int lim;
      cap = (DEPTH < MAX_EMIT) ? DEPTH : MAX_EMIT;
      lim = client_limit;
      if (lim < 1) lim = 1;
      if (lim > cap) lim = cap;
      return lim;
    endfunction

    function void drop_slot(int pos);
      for (int j = pos + 1; j < active; j++) begin
        slot_addr[j-1] = slot_addr[j];
        slot_port[j-1] = slot_port[j];
      end
      active--;
    endfunction

    // Apply one accepted event to the table and queue the words it causes.
    function void note_event(logic kind, logic [ADDR_W-1:0] addr, logic [PORT_W-1:0] port);
      int    pos;
      int    lim;
      logic  ev;
      item_t w;
      pos = -1;
      lim = limit_in_force();
      ev  = 1'b0;
      for (int i = 0; i < active; i++) begin
        if (pos < 0 && slot_addr[i] == addr && slot_port[i] == port) pos = i;
      end
      if (kind == KIND_DISC) begin
        if (pos >= 0) drop_slot(pos);
        w.ent.addr = '0;
        w.ent.port = '0;
        w.status   = (pos >= 0) ? STAT_REMOVED : STAT_UNKNOWN;
        w.evicted  = 1'b0;
        w.last     = 1'b1;
        due_words.push_back(w);
        return;
      end
      if (pos >= 0) begin
        drop_slot(pos);
      end else begin
        while (active >= lim && active > 0) begin
          drop_slot(0);
          ev = 1'b1;
        end
      end
      if (active < DEPTH) begin
        slot_addr[active] = addr;
        slot_port[active] = port;
        active++;
      end
      // limit may have been lowered below the count
      while (active > lim) begin
        drop_slot(0);
        ev = 1'b1;
      end
      for (int i = 0; i < active && i < MAX_EMIT; i++) begin
        w.ent.addr = slot_addr[i];
        w.ent.port = slot_port[i];
        w.status   = STAT_BCAST;
        w.evicted  = ev;
        w.last     = (i + 1 == active);
        due_words.push_back(w);
      end
    endfunction

    function void check_word(logic [OUT_TDATA_W-1:0] data, logic [1:0] user, logic last);
      item_t w;
      if (due_words.size() == 0) begin
        $error("unexpected output word: tdata %0h tuser %0d tlast %0b", data, user, last);
        mismatches++;
        return;
      end
      w = due_words.pop_front();
      if (data[31:0] !== w.ent.addr) begin
        $error("dest_addr: expected %0h, got %0h", w.ent.addr, data[31:0]);
        mismatches++;
      end
      if (data[47:32] !== w.ent.port) begin
        $error("dest_port: expected %0h, got %0h", w.ent.port, data[47:32]);
        mismatches++;
      end
      if (data[48] !== w.evicted) begin
        $error("evicted: expected %0b, got %0b", w.evicted, data[48]);
        mismatches++;
      end
      if (data[OUT_TDATA_W-1:49] !== '0) begin
        $error("pad: expected 0, got %0h", data[OUT_TDATA_W-1:49]);
        mismatches++;
      end
      if (user !== w.status) begin
        $error("status: expected %0d, got %0d", w.status, user);
        mismatches++;
      end
      if (last !== w.last) begin
        $error("last: expected %0b, got %0b", w.last, last);
        mismatches++;
      end
    endfunction
  endclass

  logic                   clk       = 1'b0;
  logic                   rst_n     = 1'b0;
  logic                   cfg_we    = 1'b0;
  logic [CFG_W-1:0]       cfg_wdata = '0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata  = '0;
  logic                   in_tuser  = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [1:0]             out_tuser;
  logic                   out_tlast;

  lct_scoreboard     sb = new();
  int                send_idle_pct = 0;
  int                recv_idle_pct = 0;
  int                hold_left     = 0;
  int                cycle_count   = 0;
  logic [ADDR_W-1:0] pool_addr[POOL_SIZE];
  logic [PORT_W-1:0] pool_port[POOL_SIZE];

  lru_client_table_broadcast_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > MAX_CYCLES) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // receiver: random stalls, or a long hold-off when one is requested
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_word(out_tdata, out_tuser, out_tlast);
  end

  task automatic send_event(logic kind, logic [ADDR_W-1:0] addr, logic [PORT_W-1:0] port);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {port, addr};
    do @(posedge clk); while (!in_tready);
    sb.note_event(kind, addr, port);
  endtask

  // hold the sender until every due word is out and the block has settled
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_limit(logic [CFG_W-1:0] v);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.set_limit(v);
  endtask

  task automatic run_random(int count);
    int  r;
    int  idx;
    for (int n = 0; n < count; n++) begin
      r   = $urandom_range(99);
      idx = $urandom_range(POOL_SIZE - 1);
      if (r < 8) begin
        send_event(1'($urandom), $urandom, 16'($urandom));
      end else begin
        // occasionally replace a pool client so fresh endpoints keep arriving
        if (r < 12) pool_addr[idx] = $urandom;
        send_event(($urandom_range(99) < 22) ? KIND_DISC : KIND_MSG,
                   pool_addr[idx], pool_port[idx]);
      end
    end
  endtask

  initial begin
    for (int i = 0; i < POOL_SIZE; i++) begin
      pool_addr[i] = $urandom;
      pool_port[i] = 16'($urandom);
      // neighbors that share an address or a port with another client
      if (i % 4 == 1) pool_addr[i] = pool_addr[i-1];
      if (i % 4 == 2) pool_port[i] = pool_port[i-1];
    end
    send_idle_pct = 11;
    recv_idle_pct = 45;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_event(KIND_DISC, 32'h0, 16'h0);
    send_event(KIND_MSG, 32'h0, 16'h0);
    send_event(KIND_MSG, 32'hFFFF_FFFF, 16'hFFFF);
    send_event(KIND_MSG, 32'h0, 16'h0);
    send_event(KIND_MSG, 32'h0, 16'hFFFF);
    send_event(KIND_DISC, 32'hFFFF_FFFF, 16'hFFFF);
    send_event(KIND_DISC, 32'hFFFF_FFFF, 16'h0);
    write_limit(5'd1);
    send_event(KIND_MSG, 32'h0, 16'hFFFF);
    write_limit(5'd0);
    send_event(KIND_MSG, 32'hFFFF_FFFF, 16'h0);
    write_limit(5'd31);
    for (int i = 0; i < 17; i++) send_event(KIND_MSG, $urandom, 16'(i));

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 11 : (ph == 1) ? 45 : 0;
      recv_idle_pct = (ph == 0) ? 45 : (ph == 1) ? 11 : 0;
      for (int blk = 0; blk < 3; blk++) begin
        case (ph * 3 + blk)
          0:       write_limit(5'd16);
          1:       write_limit(5'd1);
          2:       write_limit(5'd31);
          3:       write_limit(5'd3);
          4:       write_limit(5'd0);
          5:       write_limit(5'($urandom_range(2, 15)));
          6:       write_limit(5'd8);
          7:       write_limit(5'd16);
          default: write_limit(5'($urandom_range(2, 31)));
        endcase
        // block the output while the sender keeps offering words
        if (ph == 2 && blk == 0) hold_left = 400;
        run_random(50);
      end
    end

    drain_results();
    repeat (40) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
